@@ src/assert_macros.svh @@
// assertion macros used by the allocator top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, idle during reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/pba_pkg.sv @@
// types and codes for the page bitmap allocator
package pba_pkg;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_TEST    = 2'd2,
		REQ_RESERVE = 2'd3
	} req_e_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_NOFREE   = 3'd1,
		STS_CONFLICT = 3'd2,
		STS_NOTUSED  = 3'd3,
		STS_RANGE    = 3'd4
	} status_e_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_FREE,
		S_TEST,
		S_RCHK,
		S_RSET,
		S_RESP
	} state_e_t;

	typedef struct packed {
		logic       found;
		logic [4:0] idx;
	} ffs_res_t;

endpackage

@@ src/pba_ffs.sv @@
// lowest set bit finder over one bitmap word
module pba_ffs
	import pba_pkg::*;
(
	input  logic [31:0] bits,
	output ffs_res_t    res
);

	always_comb begin
		res.found = 1'b0;
		res.idx   = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (bits[i]) begin
				res.found = 1'b1;
				res.idx   = 5'(i);
			end
		end
	end

endmodule

@@ src/page_bitmap_allocator_top.sv @@
// page bitmap allocator: bitmap memory, request sequencer and result register
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: phys_addr, range_bytes
// m_*      out  m_tvalid/m_tready  m_tdata: status, page_addr, page_used
//
// free and test read the addressed map word and then load the result; out-of-range
// and empty requests load the result at once; allocate scans map words upward from
// the lowest word that may hold a free page; reserve makes a check pass and, if no
// conflict, a set pass over every word spanned; after reset a clearing pass writes
// every map word with s_tready low; one request is worked at a time
// a new request is taken while the previous result waits; a full output stalls it
module page_bitmap_allocator_top
	import pba_pkg::*;
#(
	parameter int NUM_PAGES = 16384,
	parameter int PAGE_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // [1:0] req_type
	input  logic [63:0] s_tdata,  // [31:0] phys_addr, [63:32] range_bytes
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // [2:0] status, [34:3] page_addr, [35] page_used
);

	`include "assert_macros.svh"

	localparam int MAP_WORDS = (NUM_PAGES + 31) / 32;
	localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);

	logic [31:0]    map_mem [MAP_WORDS];
	logic [31:0]    rdata_q;

	state_e_t       state_q, state_d;
	logic [WW-1:0]  word_q, word_d;
	logic [WW-1:0]  hint_q, hint_d;
	logic [WW-1:0]  first_word_q, last_word_q;
	logic [4:0]     first_bit_q, last_bit_q;
	logic [2:0]     res_status_q;
	logic [31:0]    res_paddr_q;
	logic           res_used_q;
	logic           m_tvalid_q;
	logic [39:0]    m_tdata_q;

	logic           rd_en, wr_en;
	logic [WW-1:0]  rd_addr;
	logic [31:0]    wr_data;
	logic           res_ld;
	logic [2:0]     res_status_d;
	logic [31:0]    res_paddr_d;
	logic           res_used_d;

	logic           accept;
	req_e_t         req_type;
	logic [32:0]    pg_w, cnt_w, end_w, last_w;
	logic           pg_bad, rsv_bad, rsv_empty;
	logic [WW-1:0]  pg_word;
	logic [31:0]    rmask;
	logic [WW+4:0]  found_pg;
	logic [63:0]    found_addr;
	ffs_res_t       ffs;

	function automatic logic [31:0] range_mask(input logic [4:0] lo, input logic [4:0] hi);
		range_mask = ({32{1'b1}} << lo) & ({32{1'b1}} >> (5'd31 - hi));
	endfunction

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign req_type  = req_e_t'(s_tuser);
	assign pg_w      = {1'b0, s_tdata[31:0]} >> PAGE_BITS;
	assign cnt_w     = {1'b0, s_tdata[63:32]} >> PAGE_BITS;
	assign end_w     = pg_w + cnt_w;
	assign last_w    = end_w - 33'd1;
	assign pg_bad    = (pg_w >= 33'(NUM_PAGES));
	assign rsv_bad   = (end_w > 33'(NUM_PAGES));
	assign rsv_empty = (cnt_w == 33'd0);
	assign pg_word   = pg_w[WW+4:5];

	assign rmask = range_mask((word_q == first_word_q) ? first_bit_q : 5'd0,
		(word_q == last_word_q) ? last_bit_q : 5'd31);
	assign found_pg   = {word_q, ffs.idx};
	assign found_addr = 64'(found_pg) << PAGE_BITS;

	pba_ffs u_ffs (
		.bits (~rdata_q),
		.res  (ffs)
	);

	always_comb begin
		state_d      = state_q;
		word_d       = word_q;
		hint_d       = hint_q;
		rd_en        = 1'b0;
		rd_addr      = word_q + 1'b1;
		wr_en        = 1'b0;
		wr_data      = 32'd0;
		res_ld       = 1'b0;
		res_status_d = STS_OK;
		res_paddr_d  = 32'd0;
		res_used_d   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				wr_en  = 1'b1;
				word_d = word_q + 1'b1;
				if (word_q == LAST_WORD) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_ALLOC: begin
							rd_en   = 1'b1;
							rd_addr = hint_q;
							state_d = S_ALLOC;
						end
						REQ_FREE, REQ_TEST: begin
							if (pg_bad) begin
								res_ld       = 1'b1;
								res_status_d = STS_RANGE;
								state_d      = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = pg_word;
								state_d = (req_type == REQ_FREE) ? S_FREE : S_TEST;
							end
						end
						default: begin
							if (rsv_bad) begin
								res_ld       = 1'b1;
								res_status_d = STS_RANGE;
								state_d      = S_RESP;
							end else if (rsv_empty) begin
								res_ld  = 1'b1;
								state_d = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = pg_word;
								state_d = S_RCHK;
							end
						end
					endcase
					word_d = rd_addr;
				end
			end
			S_ALLOC: begin
				if (ffs.found) begin
					res_ld  = 1'b1;
					state_d = S_RESP;
					if (32'(found_pg) < 32'(NUM_PAGES)) begin
						wr_en       = 1'b1;
						wr_data     = rdata_q | (32'd1 << ffs.idx);
						hint_d      = word_q;
						res_paddr_d = found_addr[31:0];
					end else begin
						res_status_d = STS_NOFREE;
					end
				end else if (word_q == LAST_WORD) begin
					res_ld       = 1'b1;
					res_status_d = STS_NOFREE;
					state_d      = S_RESP;
				end else begin
					rd_en  = 1'b1;
					word_d = rd_addr;
				end
			end
			S_FREE: begin
				res_ld  = 1'b1;
				state_d = S_RESP;
				if (!rdata_q[first_bit_q]) begin
					res_status_d = STS_NOTUSED;
				end else begin
					wr_en   = 1'b1;
					wr_data = rdata_q & ~(32'd1 << first_bit_q);
					if (word_q < hint_q) begin
						hint_d = word_q;
					end
				end
			end
			S_TEST: begin
				res_ld     = 1'b1;
				res_used_d = rdata_q[first_bit_q];
				state_d    = S_RESP;
			end
			S_RCHK: begin
				if ((rdata_q & rmask) != 32'd0) begin
					res_ld       = 1'b1;
					res_status_d = STS_CONFLICT;
					state_d      = S_RESP;
				end else if (word_q == last_word_q) begin
					rd_en   = 1'b1;
					rd_addr = first_word_q;
					word_d  = first_word_q;
					state_d = S_RSET;
				end else begin
					rd_en  = 1'b1;
					word_d = rd_addr;
				end
			end
			S_RSET: begin
				wr_en   = 1'b1;
				wr_data = rdata_q | rmask;
				if (word_q == last_word_q) begin
					res_ld  = 1'b1;
					state_d = S_RESP;
				end else begin
					rd_en  = 1'b1;
					word_d = rd_addr;
				end
			end
			S_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			word_q  <= '0;
			hint_q  <= '0;
		end else begin
			state_q <= state_d;
			word_q  <= word_d;
			hint_q  <= hint_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[word_q] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= map_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_word_q <= pg_word;
			first_bit_q  <= pg_w[4:0];
			last_word_q  <= last_w[WW+4:5];
			last_bit_q   <= last_w[4:0];
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_paddr_q  <= res_paddr_d;
			res_used_q   <= res_used_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_RESP && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {4'd0, res_used_q, res_paddr_q, res_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_IMPLIES(a_no_rw_same_word, clk, arst_n, wr_en && rd_en, rd_addr != word_q)
	`ASSERT_IMPLIES(a_hint_in_map, clk, arst_n, state_q != S_CLEAR, hint_q <= LAST_WORD)
	`ASSERT_NEXT(a_result_shown, clk, arst_n, state_q == S_RESP && (!m_tvalid_q || m_tready), m_tvalid)

endmodule

@@ test/tb_top.sv @@
// testbench for page_bitmap_allocator_top: streamed requests checked against a bitmap predictor
`timescale 1ns / 100ps

module tb_top;
	import pba_pkg::*;

	localparam int NUM_PAGES = 16384;
	localparam int PAGE_BITS = 12;
	localparam int MAP_WORDS = (NUM_PAGES + 31) / 32;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int RANDOM_REQUESTS = 1500;

	typedef struct {
		req_e_t      kind;
		logic [31:0] addr;
		logic [31:0] len;
	} page_req_t;

	typedef struct {
		status_e_t   status;
		logic [31:0] page_addr;
		logic        page_used;
	} page_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;   // [1:0] req_type
	logic [63:0] s_tdata = '0;   // [31:0] phys_addr, [63:32] range_bytes
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [2:0] status, [34:3] page_addr, [35] page_used

	logic [31:0] page_map [MAP_WORDS];
	page_req_t   page_requests[$];
	page_resp_t  due_replies[$];
	page_req_t   on_offer;
	page_resp_t  seen_reply;
	page_resp_t  due_reply;
	int          status_tally [8];
	int          sent_count;
	int          replies_seen;
	int          hold_left;
	logic        hold_done;
	int          mismatches = 0;
	int          cycles = 0;
	logic        calm;

	page_bitmap_allocator_top #(
		.NUM_PAGES(NUM_PAGES),
		.PAGE_BITS(PAGE_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// no idling on either side for a stretch in the middle of the run
	assign calm = sent_count >= 600 && sent_count < 900;

	function automatic page_resp_t apply_page_request(page_req_t rq);
		page_resp_t  rs;
		logic [31:0] pg;
		logic [31:0] cnt;
		logic [32:0] span;
		int unsigned found;
		bit          hit;
		rs.status = STS_OK;
		rs.page_addr = '0;
		rs.page_used = 1'b0;
		pg = rq.addr >> PAGE_BITS;
		cnt = rq.len >> PAGE_BITS;
		found = 0;
		hit = 1'b0;
		case (rq.kind)
			REQ_ALLOC: begin
				for (int w = 0; w < MAP_WORDS && !hit; w++) begin
					if (~page_map[w] != 32'd0) begin
						for (int b = 31; b >= 0; b--)
							if (!page_map[w][b])
								found = w * 32 + b;
						hit = 1'b1;
					end
				end
				if (hit && found < NUM_PAGES) begin
					page_map[found / 32][found % 32] = 1'b1;
					rs.page_addr = found << PAGE_BITS;
				end else begin
					rs.status = STS_NOFREE;
				end
			end
			REQ_FREE: begin
				if (pg >= NUM_PAGES)
					rs.status = STS_RANGE;
				else if (!page_map[pg >> 5][pg[4:0]])
					rs.status = STS_NOTUSED;
				else
					page_map[pg >> 5][pg[4:0]] = 1'b0;
			end
			REQ_TEST: begin
				if (pg >= NUM_PAGES)
					rs.status = STS_RANGE;
				else
					rs.page_used = page_map[pg >> 5][pg[4:0]];
			end
			default: begin
				span = {1'b0, pg} + {1'b0, cnt};
				if (span > 33'(NUM_PAGES)) begin
					rs.status = STS_RANGE;
				end else begin
					for (int unsigned i = 0; i < cnt; i++)
						if (page_map[(pg + i) >> 5][(pg + i) % 32])
							rs.status = STS_CONFLICT;
					if (rs.status == STS_OK)
						for (int unsigned i = 0; i < cnt; i++)
							page_map[(pg + i) >> 5][(pg + i) % 32] = 1'b1;
				end
			end
		endcase
		status_tally[rs.status]++;
		return rs;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 30)
			$display("mismatch at reply %0d, %s: expected %0h, got %0h",
				replies_seen, field, want, got);
	endtask

	task automatic queue_request(req_e_t kind, logic [31:0] addr, logic [31:0] len);
		page_req_t rq;
		rq.kind = kind;
		rq.addr = addr;
		rq.len = len;
		page_requests.push_back(rq);
	endtask

	function automatic logic [31:0] pick_addr();
		int unsigned r;
		int unsigned pg;
		logic [31:0] low;
		r = $urandom_range(0, 99);
		low = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 0;
		if (r < 70)
			pg = $urandom_range(0, 511);
		else if (r < 88)
			pg = $urandom_range(0, NUM_PAGES - 1);
		else if (r < 95)
			return $urandom();
		else
			pg = $urandom_range(NUM_PAGES - 4, NUM_PAGES + 16);
		return (pg << PAGE_BITS) | low;
	endfunction

	function automatic logic [31:0] pick_len();
		int unsigned r;
		int unsigned cnt;
		logic [31:0] low;
		r = $urandom_range(0, 99);
		low = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 0;
		if (r < 75)
			cnt = $urandom_range(0, 40);
		else if (r < 85)
			cnt = $urandom_range(0, 600);
		else if (r < 95)
			return $urandom();
		else
			cnt = $urandom_range(NUM_PAGES - 400, NUM_PAGES);
		return (cnt << PAGE_BITS) | low;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser <= REQ_ALLOC;
			s_tdata <= '0;
			sent_count <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				due_replies.push_back(apply_page_request(on_offer));
				sent_count <= sent_count + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (page_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 35)) begin
					on_offer = page_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= on_offer.kind;
					s_tdata <= {on_offer.len, on_offer.addr};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// reply monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			replies_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_reply.status = status_e_t'(m_tdata[2:0]);
				seen_reply.page_addr = m_tdata[34:3];
				seen_reply.page_used = m_tdata[35];
				if (due_replies.size() == 0) begin
					report_mismatch("reply with no request", 0, m_tdata[34:3]);
				end else begin
					due_reply = due_replies.pop_front();
					if (seen_reply.status !== due_reply.status)
						report_mismatch("status", due_reply.status, seen_reply.status);
					if (seen_reply.page_addr !== due_reply.page_addr)
						report_mismatch("page_addr", due_reply.page_addr, seen_reply.page_addr);
					if (seen_reply.page_used !== due_reply.page_used)
						report_mismatch("page_used", due_reply.page_used, seen_reply.page_used);
				end
				replies_seen <= replies_seen + 1;
			end
			if (hold_left > 0)
				m_tready <= 1'b0;
			else
				m_tready <= calm || $urandom_range(0, 99) >= 35;
		end
	end

	// one long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && replies_seen >= 200) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		int          run_start;
		foreach (page_map[w])
			page_map[w] = '0;
		foreach (status_tally[i])
			status_tally[i] = 0;

		// directed requests on an empty map
		queue_request(REQ_ALLOC, 32'h0, 32'h0);
		queue_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(REQ_TEST, 32'h0000_0FFF, 32'h0);
		queue_request(REQ_TEST, 32'h0000_5000, 32'h0);
		queue_request(REQ_FREE, 32'h0000_1000, 32'h0);
		queue_request(REQ_FREE, 32'h0000_1ABC, 32'h0);
		queue_request(REQ_FREE, 32'h0400_0000, 32'h0);
		queue_request(REQ_TEST, 32'hFFFF_FFFF, 32'h0);
		queue_request(REQ_RESERVE, 32'h0000_A000, 32'h0000_4FFF);
		queue_request(REQ_RESERVE, 32'h0000_C000, 32'h0000_3000);
		queue_request(REQ_RESERVE, 32'h0000_0000, 32'h0000_0000);
		queue_request(REQ_RESERVE, 32'h0400_0FFF, 32'h0000_0FFF);
		queue_request(REQ_RESERVE, 32'h0400_1000, 32'h0000_0000);
		queue_request(REQ_RESERVE, 32'h03FF_C000, 32'h0000_5000);
		queue_request(REQ_RESERVE, 32'hFFFF_F000, 32'hFFFF_FFFF);
		queue_request(REQ_ALLOC, 32'h0, 32'h0);
		queue_request(REQ_TEST, 32'h0000_D000, 32'h0);
		queue_request(REQ_FREE, 32'h0000_B000, 32'h0);
		queue_request(REQ_FREE, 32'h0000_0000, 32'h0);
		queue_request(REQ_ALLOC, 32'h0, 32'h0);
		queue_request(REQ_ALLOC, 32'h0, 32'h0);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				queue_request(REQ_ALLOC, $urandom(), $urandom());
			else if (r < 55)
				queue_request(REQ_FREE, pick_addr(), $urandom());
			else if (r < 75)
				queue_request(REQ_TEST, pick_addr(), $urandom());
			else
				queue_request(REQ_RESERVE, pick_addr(), pick_len());
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (page_requests.size() > 0 || s_tvalid || due_replies.size() > 0)
			@(posedge clk);

		// fill every free page so allocate runs dry, then reopen the last and first pages
		@(negedge clk);
		run_start = -1;
		for (int p = 0; p <= NUM_PAGES; p++) begin
			if (p < NUM_PAGES && !page_map[p / 32][p % 32]) begin
				if (run_start < 0)
					run_start = p;
			end else if (run_start >= 0) begin
				queue_request(REQ_RESERVE, run_start << PAGE_BITS,
					(p - run_start) << PAGE_BITS);
				run_start = -1;
			end
		end
		queue_request(REQ_ALLOC, 32'h0, 32'h0);
		queue_request(REQ_TEST, 32'h03FF_F000, 32'h0);
		queue_request(REQ_FREE, 32'h03FF_FFFF, 32'h0);
		queue_request(REQ_ALLOC, 32'h0, 32'h0);
		queue_request(REQ_ALLOC, 32'h0, 32'h0);
		queue_request(REQ_FREE, 32'h0000_0000, 32'h0);
		queue_request(REQ_ALLOC, 32'h0, 32'h0);
		queue_request(REQ_RESERVE, 32'h0000_0000, 32'h0400_0000);

		while (page_requests.size() > 0 || s_tvalid || due_replies.size() > 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);

		if (due_replies.size() > 0)
			report_mismatch("replies never arrived", due_replies.size(), 0);
		$display("%0d requests, %0d replies: %0d ok, %0d no free page, %0d conflict",
			sent_count, replies_seen, status_tally[STS_OK], status_tally[STS_NOFREE],
			status_tally[STS_CONFLICT]);
		$display("%0d frees of unused pages, %0d out of range, one long reply stall",
			status_tally[STS_NOTUSED], status_tally[STS_RANGE]);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ page_bitmap_allocator_top.f @@
+incdir+src
src/pba_pkg.sv
src/pba_ffs.sv
src/page_bitmap_allocator_top.sv
test/tb_top.sv
